// File: src/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCC_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tcc_pkg.sv
// Shared types, constants and command/status structs of the text console.
package tcc_pkg;

    localparam int DEF_COLUMNS  = 80;
    localparam int DEF_ROWS     = 25;
    localparam int DEF_TAB_STOP = 4;

    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int POS_W     = 8;
    localparam int COLOR_W   = 8;
    localparam int OUT_COL_W = 7;
    localparam int OUT_ROW_W = 5;
    localparam int OFFSET_W  = 11;
    localparam int CELL_W    = 16;

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    localparam logic [PADDR_W-3:0] REG_TEXT_COLOR   = '0;
    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h0F;

    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_SET   = 2'd2,
        OP_READ  = 2'd3
    } tcc_op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_FILL,
        ST_DONE
    } tcc_state_t;

    typedef struct packed {
        logic load_item;
        logic cur_update;
        logic home;
        logic ptr_clr;
        logic ptr_inc;
        logic wr_char;
        logic wr_copy;
        logic wr_fill;
        logic fill_zero;
        logic rd_cell;
        logic res_load;
    } tcc_cmd_t;

    typedef struct packed {
        tcc_op_t op;
        logic    is_char;
        logic    need_scroll;
        logic    ptr_copy_end;
        logic    ptr_end;
        logic    out_free;
    } tcc_stat_t;

endpackage

// File: src/tcc_in_if.sv
// Input item channel of the text console.
interface tcc_in_if;
    import tcc_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  col_in;
    logic [POS_W-1:0]  row_in;

    modport source (output valid, operation, char_code, col_in, row_in, input ready);
    modport sink (input valid, operation, char_code, col_in, row_in, output ready);
endinterface

// File: src/tcc_out_if.sv
// Result item channel of the text console.
interface tcc_out_if;
    import tcc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUT_COL_W-1:0] cursor_col;
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [OFFSET_W-1:0]  cursor_offset;
    logic [CELL_W-1:0]    cell_word;

    modport source (output valid, cursor_col, cursor_row, cursor_offset, cell_word, input ready);
    modport sink (input valid, cursor_col, cursor_row, cursor_offset, cell_word, output ready);
endinterface

// File: src/text_console_cursor_scroll.sv
// Top level of the text console: controller, datapath and APB register file.
// An item is accepted in the idle state and executed in the exec state; its result is
// registered in the done state once the result register is free, and only then is the
// next item accepted. A scroll passes through the scroll and fill states before done,
// a clear through the fill state. After reset a clearing pass zeroes the store before
// the first item is accepted; configuration writes are taken throughout.
module text_console_cursor_scroll #(
    parameter int COLUMNS  = tcc_pkg::DEF_COLUMNS,
    parameter int ROWS     = tcc_pkg::DEF_ROWS,
    parameter int TAB_STOP = tcc_pkg::DEF_TAB_STOP
) (
    input  logic                           clk,
    input  logic                           rst_n,
    tcc_in_if.sink                         in_item,
    tcc_out_if.source                      out_item,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcc_pkg::PADDR_W-1:0]    paddr,
    input  logic [tcc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tcc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import tcc_pkg::*;

    tcc_cmd_t           cmd;
    tcc_stat_t          stat;
    logic [COLOR_W-1:0] text_color;

    tcc_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .text_color (text_color)
    );

    tcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_item.valid),
        .in_ready (in_item.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcc_dpath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (in_item.operation),
        .char_code     (in_item.char_code),
        .col_in        (in_item.col_in),
        .row_in        (in_item.row_in),
        .text_color    (text_color),
        .out_ready     (out_item.ready),
        .out_valid     (out_item.valid),
        .cursor_col    (out_item.cursor_col),
        .cursor_row    (out_item.cursor_row),
        .cursor_offset (out_item.cursor_offset),
        .cell_word     (out_item.cell_word)
    );
endmodule

// File: src/tcc_cfg.sv
// APB register file holding the text color attribute.
module tcc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcc_pkg::PADDR_W-1:0]    paddr,
    input  logic [tcc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tcc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [tcc_pkg::COLOR_W-1:0]    text_color
);
    import tcc_pkg::*;

    logic [COLOR_W-1:0] color_reg;
    logic               hit;
    logic               wr_en;

    assign hit    = paddr[PADDR_W-1:2] == REG_TEXT_COLOR;
    assign wr_en  = psel && penable && pwrite && hit;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= TEXT_COLOR_RESET;
        end
        else if (wr_en)
        begin
            color_reg <= pwdata[COLOR_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (psel && hit)
        begin
            prdata = {{(APB_DATA_W-COLOR_W){1'b0}}, color_reg};
        end
    end

    assign text_color = color_reg;
endmodule

// File: src/tcc_ctrl.sv
// Controller state machine sequencing item execution and screen store sweeps.
module tcc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tcc_pkg::tcc_stat_t stat,
    output tcc_pkg::tcc_cmd_t  cmd
);
    import tcc_pkg::*;

    tcc_state_t state_reg;
    tcc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (stat.ptr_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (stat.op)
                    OP_PUT:   state_next = stat.need_scroll ? ST_SCROLL : ST_DONE;
                    OP_CLEAR: state_next = ST_FILL;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_SCROLL:
            begin
                if (stat.ptr_copy_end)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (stat.ptr_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.wr_fill   = 1'b1;
                cmd.fill_zero = 1'b1;
                cmd.ptr_inc   = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_EXEC:
            begin
                case (stat.op)
                    OP_PUT:
                    begin
                        cmd.wr_char    = stat.is_char;
                        cmd.cur_update = 1'b1;
                        cmd.ptr_clr    = stat.need_scroll;
                    end
                    OP_CLEAR:
                    begin
                        cmd.home    = 1'b1;
                        cmd.ptr_clr = 1'b1;
                    end
                    OP_SET:
                    begin
                        cmd.cur_update = 1'b1;
                    end
                    default:
                    begin
                        cmd.rd_cell = 1'b1;
                    end
                endcase
            end
            ST_SCROLL:
            begin
                cmd.wr_copy = 1'b1;
                cmd.ptr_inc = 1'b1;
            end
            ST_FILL:
            begin
                cmd.wr_fill = 1'b1;
                cmd.ptr_inc = 1'b1;
            end
            ST_DONE:
            begin
                cmd.res_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end
endmodule

// File: src/tcc_dpath.sv
// Datapath: item registers, cursor, screen store with sweep pointer, result register.
module tcc_dpath #(
    parameter int COLUMNS  = tcc_pkg::DEF_COLUMNS,
    parameter int ROWS     = tcc_pkg::DEF_ROWS,
    parameter int TAB_STOP = tcc_pkg::DEF_TAB_STOP
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcc_pkg::tcc_cmd_t             cmd,
    output tcc_pkg::tcc_stat_t            stat,
    input  logic [tcc_pkg::OP_W-1:0]      operation,
    input  logic [tcc_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcc_pkg::POS_W-1:0]     col_in,
    input  logic [tcc_pkg::POS_W-1:0]     row_in,
    input  logic [tcc_pkg::COLOR_W-1:0]   text_color,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [tcc_pkg::OUT_COL_W-1:0] cursor_col,
    output logic [tcc_pkg::OUT_ROW_W-1:0] cursor_row,
    output logic [tcc_pkg::OFFSET_W-1:0]  cursor_offset,
    output logic [tcc_pkg::CELL_W-1:0]    cell_word
);
    import tcc_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int CW         = $clog2(COLUMNS);
    localparam int RW         = $clog2(ROWS);
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int XW         = $clog2(COLUMNS + TAB_STOP + 1);
    localparam int NTAB       = COLUMNS / TAB_STOP + 1;

    localparam logic [POS_W:0]  COL_LIM    = (POS_W + 1)'(COLUMNS);
    localparam logic [POS_W:0]  ROW_LIM    = (POS_W + 1)'(ROWS);
    localparam logic [AW-1:0]   COPY_LAST  = AW'(CELL_COUNT - COLUMNS - 1);
    localparam logic [AW-1:0]   CELL_LAST  = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0]   ROW_STRIDE = AW'(COLUMNS);
    localparam logic [RW-1:0]   ROW_LAST   = RW'(ROWS - 1);

    logic [OP_W-1:0]   op_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic [POS_W-1:0]  col_in_reg;
    logic [POS_W-1:0]  row_in_reg;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_next;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;

    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic              rd_en;

    logic              wr_pend_reg;
    logic              wr_copy_reg;
    logic [AW-1:0]     wr_addr_reg;
    logic [CELL_W-1:0] wr_word_reg;
    logic [AW-1:0]     wr_addr_next;
    logic [CELL_W-1:0] wr_word_next;

    logic                 out_valid_reg;
    logic [OUT_COL_W-1:0] cursor_col_reg;
    logic [OUT_ROW_W-1:0] cursor_row_reg;
    logic [OFFSET_W-1:0]  cursor_offset_reg;
    logic [CELL_W-1:0]    cell_word_reg;

    logic                    is_lf;
    logic                    is_cr;
    logic                    is_tab;
    logic                    is_bs;
    logic                    on_screen;
    logic [AW-1:0]           cur_addr;
    logic [AW-1:0]           item_addr;
    logic [XW-1:0]           tab_col;
    logic [XW-1:0]           col_tmp;
    logic                    row_inc;
    logic                    at_last_row;
    logic [CW-1:0]           col_put;
    logic [RW-1:0]           row_put;
    logic [CW+OUT_COL_W-1:0] col_wide;
    logic [RW+OUT_ROW_W-1:0] row_wide;
    logic [AW+OFFSET_W-1:0]  addr_wide;

    assign is_lf  = ch_reg == CH_LF;
    assign is_cr  = ch_reg == CH_CR;
    assign is_tab = ch_reg == CH_TAB;
    assign is_bs  = ch_reg == CH_BS;

    assign on_screen = ({1'b0, col_in_reg} < COL_LIM) && ({1'b0, row_in_reg} < ROW_LIM);
    assign cur_addr  = AW'(row_reg) * ROW_STRIDE + AW'(col_reg);
    assign item_addr = AW'(row_in_reg[RW-1:0]) * ROW_STRIDE + AW'(col_in_reg[CW-1:0]);

    // Next tab stop: the smallest multiple of the stop width above the column.
    always_comb
    begin
        tab_col = '0;
        for (int k = NTAB; k >= 1; k--)
        begin
            if (XW'(k * TAB_STOP) > XW'(col_reg))
            begin
                tab_col = XW'(k * TAB_STOP);
            end
        end
    end

    always_comb
    begin
        row_inc = 1'b0;
        if (is_lf)
        begin
            col_tmp = '0;
            row_inc = 1'b1;
        end
        else if (is_cr)
        begin
            col_tmp = '0;
        end
        else if (is_tab)
        begin
            col_tmp = tab_col;
        end
        else if (is_bs)
        begin
            col_tmp = (col_reg == '0) ? '0 : XW'(col_reg) - XW'(1);
        end
        else
        begin
            col_tmp = XW'(col_reg) + XW'(1);
        end

        if (col_tmp >= XW'(COLUMNS))
        begin
            col_put = '0;
            row_inc = 1'b1;
        end
        else
        begin
            col_put = col_tmp[CW-1:0];
        end

        at_last_row = row_reg == ROW_LAST;
        row_put     = (row_inc && !at_last_row) ? row_reg + RW'(1) : row_reg;
    end

    always_comb
    begin
        stat              = '0;
        stat.op           = tcc_op_t'(op_reg);
        stat.is_char      = !(is_lf || is_cr || is_tab || is_bs);
        stat.need_scroll  = row_inc && at_last_row;
        stat.ptr_copy_end = ptr_reg == COPY_LAST;
        stat.ptr_end      = ptr_reg == CELL_LAST;
        stat.out_free     = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg     <= operation;
            ch_reg     <= char_code;
            col_in_reg <= col_in;
            row_in_reg <= row_in;
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.home)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (cmd.cur_update)
        begin
            if (tcc_op_t'(op_reg) == OP_SET)
            begin
                if (on_screen)
                begin
                    col_next = col_in_reg[CW-1:0];
                    row_next = row_in_reg[RW-1:0];
                end
            end
            else
            begin
                col_next = col_put;
                row_next = row_put;
            end
        end

        ptr_next = ptr_reg;
        if (cmd.ptr_clr)
        begin
            ptr_next = '0;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            ptr_reg     <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            ptr_reg     <= ptr_next;
            wr_pend_reg <= cmd.wr_char || cmd.wr_copy || cmd.wr_fill;
        end
    end

    // Every write goes through one stage so a copy can use the data that its read registered.
    always_comb
    begin
        wr_addr_next = cmd.wr_char ? cur_addr : ptr_reg;
        if (cmd.wr_char)
        begin
            wr_word_next = {text_color, ch_reg};
        end
        else if (cmd.fill_zero)
        begin
            wr_word_next = '0;
        end
        else
        begin
            wr_word_next = {text_color, CH_BLANK};
        end
    end

    always_ff @(posedge clk)
    begin
        wr_copy_reg <= cmd.wr_copy;
        wr_addr_reg <= wr_addr_next;
        wr_word_reg <= wr_word_next;
    end

    assign rd_en   = cmd.rd_cell || cmd.wr_copy;
    assign rd_addr = cmd.rd_cell ? item_addr : ptr_reg + ROW_STRIDE;

    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
        begin
            mem[wr_addr_reg] <= wr_copy_reg ? rd_data_reg : wr_word_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign col_wide  = (CW + OUT_COL_W)'(col_reg);
    assign row_wide  = (RW + OUT_ROW_W)'(row_reg);
    assign addr_wide = (AW + OFFSET_W)'(cur_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            cursor_col_reg    <= col_wide[OUT_COL_W-1:0];
            cursor_row_reg    <= row_wide[OUT_ROW_W-1:0];
            cursor_offset_reg <= addr_wide[OFFSET_W-1:0];
            cell_word_reg     <= (tcc_op_t'(op_reg) == OP_READ && on_screen) ? rd_data_reg : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_col    = cursor_col_reg;
    assign cursor_row    = cursor_row_reg;
    assign cursor_offset = cursor_offset_reg;
    assign cell_word     = cell_word_reg;
endmodule

// File: src/tcc_chk.sv
// Port-level checker for the text console, bound to the top level.
`include "assert_macros.svh"

module tcc_chk #(
    parameter int COLUMNS = tcc_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcc_pkg::DEF_ROWS
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [tcc_pkg::OUT_COL_W-1:0] cursor_col,
    input logic [tcc_pkg::OUT_ROW_W-1:0] cursor_row,
    input logic [tcc_pkg::OFFSET_W-1:0]  cursor_offset,
    input logic [tcc_pkg::CELL_W-1:0]    cell_word
);
    import tcc_pkg::*;

    `TCC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(cursor_offset) && $stable(cell_word), "result item changed while stalled")
    `TCC_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "second item accepted while one is in work")
    `TCC_ASSERT_IMPL(a_col_range, clk, rst_n, out_valid, cursor_col < COLUMNS, "cursor column off screen")
    `TCC_ASSERT_IMPL(a_offset, clk, rst_n, out_valid, ROWS > 32 || cursor_offset == OFFSET_W'(cursor_row * COLUMNS + cursor_col), "cursor offset does not match row and column")
endmodule

bind text_console_cursor_scroll tcc_chk #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_item.valid),
    .in_ready      (in_item.ready),
    .out_valid     (out_item.valid),
    .out_ready     (out_item.ready),
    .cursor_col    (out_item.cursor_col),
    .cursor_row    (out_item.cursor_row),
    .cursor_offset (out_item.cursor_offset),
    .cell_word     (out_item.cell_word)
);

// File: tb/tb_text_console_cursor_scroll.sv
// Self-checking testbench for the text console: directed table, then random items under idling.
module tb_text_console_cursor_scroll;
    import tcc_pkg::*;

    localparam int COLS      = DEF_COLUMNS;
    localparam int ROWS_N    = DEF_ROWS;
    localparam int TAB       = DEF_TAB_STOP;
    localparam int CELLS     = COLS * ROWS_N;
    localparam int ITEMS_PER_PHASE = 367;
    localparam int HOLD_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 10_000_000;

    localparam logic [PADDR_W-1:0] ADDR_TEXT_COLOR = {REG_TEXT_COLOR, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SPARE      = ADDR_TEXT_COLOR + 3'd4;

    typedef struct packed {
        tcc_op_t           op;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
    } console_cmd_t;

    typedef struct packed {
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
        logic [OFFSET_W-1:0]  offset;
        logic [CELL_W-1:0]    cell_val;
    } console_status_t;

    typedef struct packed {
        console_cmd_t    cmd;
        logic            typed;
        console_status_t status;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tcc_in_if  in_ch();
    tcc_out_if out_ch();

    text_console_cursor_scroll u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_ch),
        .out_item(out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [CELL_W-1:0]  screen_m [0:CELLS-1];
    int                 cur_c;
    int                 cur_r;
    logic [COLOR_W-1:0] color_m;

    console_status_t pending_status_q[$];
    stim_row_t       dir_q[$];
    int              mismatch_cnt;
    int              accepted_cnt;
    int              cycle_cnt;
    int              tx_idle_pct;
    int              rx_idle_pct;
    logic            rx_hold;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic console_status_t apply_cmd(input console_cmd_t c);
        console_status_t s;
        logic [CELL_W-1:0] word_val;
        int i;
        word_val = '0;
        case (c.op)
            OP_PUT:
            begin
                if (c.ch == CH_LF)
                begin
                    cur_c = 0;
                    cur_r++;
                end
                else if (c.ch == CH_CR)
                    cur_c = 0;
                else if (c.ch == CH_TAB)
                    cur_c = cur_c + TAB - (cur_c % TAB);
                else if (c.ch == CH_BS)
                begin
                    if (cur_c > 0)
                        cur_c--;
                end
                else
                begin
                    screen_m[cur_r * COLS + cur_c] = {color_m, c.ch};
                    cur_c++;
                end
                if (cur_c >= COLS)
                begin
                    cur_c = 0;
                    cur_r++;
                end
                if (cur_r >= ROWS_N)
                begin
                    for (i = 0; i < CELLS - COLS; i++)
                        screen_m[i] = screen_m[i + COLS];
                    for (i = CELLS - COLS; i < CELLS; i++)
                        screen_m[i] = {color_m, CH_BLANK};
                    cur_r = ROWS_N - 1;
                end
            end
            OP_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    screen_m[i] = {color_m, CH_BLANK};
                cur_c = 0;
                cur_r = 0;
            end
            OP_SET:
            begin
                if (c.col < COLS && c.row < ROWS_N)
                begin
                    cur_c = int'(c.col);
                    cur_r = int'(c.row);
                end
            end
            default:
            begin
                if (c.col < COLS && c.row < ROWS_N)
                    word_val = screen_m[c.row * COLS + c.col];
            end
        endcase
        s.col      = OUT_COL_W'(cur_c);
        s.row      = OUT_ROW_W'(cur_r);
        s.offset   = OFFSET_W'(cur_r * COLS + cur_c);
        s.cell_val = word_val;
        return s;
    endfunction

    function automatic void table_row(input tcc_op_t op, input logic [7:0] ch,
                                      input logic [7:0] col, input logic [7:0] row,
                                      input logic typed, input int ecol, input int erow,
                                      input int eoff, input logic [15:0] ecell);
        stim_row_t r;
        r.cmd             = '{op: op, ch: ch, col: col, row: row};
        r.typed           = typed;
        r.status.col      = OUT_COL_W'(ecol);
        r.status.row      = OUT_ROW_W'(erow);
        r.status.offset   = OFFSET_W'(eoff);
        r.status.cell_val = ecell;
        dir_q.push_back(r);
    endfunction

    function automatic console_cmd_t random_cmd();
        console_cmd_t c;
        int pick;
        int sel;
        pick  = $urandom_range(99);
        c.op  = OP_PUT;
        c.ch  = CHAR_W'($urandom_range(255));
        c.col = POS_W'($urandom_range(255));
        c.row = POS_W'($urandom_range(255));
        if (pick < 60)
        begin
            sel = $urandom_range(99);
            if (sel < 5)
                c.ch = CH_LF;
            else if (sel < 8)
                c.ch = CH_CR;
            else if (sel < 13)
                c.ch = CH_TAB;
            else if (sel < 18)
                c.ch = CH_BS;
        end
        else if (pick < 62)
            c.op = OP_CLEAR;
        else
        begin
            c.op = (pick < 80) ? OP_SET : OP_READ;
            if ($urandom_range(9) != 0)
            begin
                c.col = POS_W'($urandom_range(COLS - 1));
                c.row = POS_W'($urandom_range(ROWS_N - 1));
            end
        end
        return c;
    endfunction

    task automatic log_error(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%s", msg);
    endtask

    task automatic send_cmd(input console_cmd_t c);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= c.op;
        in_ch.char_code <= c.ch;
        in_ch.col_in    <= c.col;
        in_ch.row_in    <= c.row;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        accepted_cnt++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_status_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == ADDR_TEXT_COLOR)
            color_m = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    always @(negedge clk)
        out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

    // The receiver holds off once for a long stretch so the block fills up and stalls its input.
    initial
    begin
        rx_hold = 1'b0;
        while (accepted_cnt < 60)
            @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    always @(posedge clk)
    begin
        console_status_t got;
        console_status_t want;
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got = '{col: out_ch.cursor_col, row: out_ch.cursor_row,
                    offset: out_ch.cursor_offset, cell_val: out_ch.cell_word};
            if (pending_status_q.size() == 0)
                log_error($sformatf("Unexpected result: col=%0d row=%0d off=%0d cell=%h",
                                    got.col, got.row, got.offset, got.cell_val));
            else
            begin
                want = pending_status_q.pop_front();
                if (got !== want)
                    log_error($sformatf({"Mismatch: expected col=%0d row=%0d off=%0d cell=%h,",
                                         " got col=%0d row=%0d off=%0d cell=%h"},
                                        want.col, want.row, want.offset, want.cell_val,
                                        got.col, got.row, got.offset, got.cell_val));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int tx_pct [3];
        int rx_pct [3];
        logic [7:0] colors [3];
        console_cmd_t c;
        console_status_t s_pred;
        int i;
        int p;

        tx_pct          = '{27, 80, 0};
        rx_pct          = '{80, 27, 0};
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_PUT;
        in_ch.char_code = '0;
        in_ch.col_in    = '0;
        in_ch.row_in    = '0;
        out_ch.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        mismatch_cnt    = 0;
        accepted_cnt    = 0;
        cycle_cnt       = 0;
        tx_idle_pct     = tx_pct[0];
        rx_idle_pct     = rx_pct[0];
        for (i = 0; i < CELLS; i++)
            screen_m[i] = '0;
        cur_c   = 0;
        cur_r   = 0;
        color_m = TEXT_COLOR_RESET;
        colors  = '{8'h00, 8'hFF, 8'($urandom)};

        table_row(OP_READ,  8'h00,  8'd0,   8'd0,   1'b1, 0,  0,  0,    16'h0000);
        table_row(OP_READ,  8'h00,  8'd255, 8'd255, 1'b1, 0,  0,  0,    16'h0000);
        table_row(OP_PUT,   8'h41,  8'd0,   8'd0,   1'b1, 1,  0,  1,    16'h0000);
        table_row(OP_READ,  8'h00,  8'd0,   8'd0,   1'b1, 1,  0,  1,    {TEXT_COLOR_RESET, 8'h41});
        table_row(OP_PUT,   8'h00,  8'd0,   8'd0,   1'b0, 0,  0,  0,    16'h0000);
        table_row(OP_PUT,   8'hFF,  8'd0,   8'd0,   1'b0, 0,  0,  0,    16'h0000);
        table_row(OP_PUT,   CH_TAB, 8'd0,   8'd0,   1'b0, 0,  0,  0,    16'h0000);
        table_row(OP_PUT,   CH_TAB, 8'd0,   8'd0,   1'b0, 0,  0,  0,    16'h0000);
        table_row(OP_PUT,   CH_BS,  8'd0,   8'd0,   1'b0, 0,  0,  0,    16'h0000);
        table_row(OP_PUT,   CH_CR,  8'd0,   8'd0,   1'b0, 0,  0,  0,    16'h0000);
        table_row(OP_PUT,   CH_BS,  8'd0,   8'd0,   1'b1, 0,  0,  0,    16'h0000);
        table_row(OP_PUT,   CH_LF,  8'd0,   8'd0,   1'b1, 0,  1,  COLS, 16'h0000);
        table_row(OP_SET,   8'h00,  8'd80,  8'd0,   1'b1, 0,  1,  COLS, 16'h0000);
        table_row(OP_SET,   8'h00,  8'd0,   8'd25,  1'b1, 0,  1,  COLS, 16'h0000);
        table_row(OP_SET,   8'h00,  8'd255, 8'd255, 1'b1, 0,  1,  COLS, 16'h0000);
        table_row(OP_SET,   8'h00,  8'd79,  8'd0,   1'b1, 79, 0,  79,   16'h0000);
        table_row(OP_PUT,   8'h5A,  8'd0,   8'd0,   1'b0, 0,  0,  0,    16'h0000);
        table_row(OP_SET,   8'h00,  8'd78,  8'd0,   1'b0, 0,  0,  0,    16'h0000);
        table_row(OP_PUT,   CH_TAB, 8'd0,   8'd0,   1'b0, 0,  0,  0,    16'h0000);
        table_row(OP_SET,   8'h00,  8'd79,  8'd24,  1'b1, 79, 24, 1999, 16'h0000);
        table_row(OP_PUT,   8'h78,  8'd0,   8'd0,   1'b0, 0,  0,  0,    16'h0000);
        table_row(OP_READ,  8'h00,  8'd79,  8'd23,  1'b0, 0,  0,  0,    16'h0000);
        table_row(OP_READ,  8'h00,  8'd0,   8'd24,  1'b0, 0,  0,  0,    16'h0000);
        table_row(OP_PUT,   CH_LF,  8'd0,   8'd0,   1'b0, 0,  0,  0,    16'h0000);
        table_row(OP_CLEAR, 8'h00,  8'd0,   8'd0,   1'b1, 0,  0,  0,    16'h0000);
        table_row(OP_READ,  8'h00,  8'd40,  8'd12,  1'b0, 0,  0,  0,    16'h0000);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_q[k])
        begin
            send_cmd(dir_q[k].cmd);
            s_pred = apply_cmd(dir_q[k].cmd);
            pending_status_q.push_back(dir_q[k].typed ? dir_q[k].status : s_pred);
        end

        for (p = 0; p < 3; p++)
        begin
            drain();
            tx_idle_pct = tx_pct[p];
            rx_idle_pct = rx_pct[p];
            if (p == 0)
                apb_write(ADDR_SPARE, 8'($urandom));
            apb_write(ADDR_TEXT_COLOR, colors[p]);
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                c = random_cmd();
                send_cmd(c);
                pending_status_q.push_back(apply_cmd(c));
            end
        end

        drain();
        mismatch_cnt += pending_status_q.size();
        if (mismatch_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
